// File: design/tbm_pkg.sv
// Shared widths, payload types and index helpers for the tetrahedron inverse core.
package tbm_pkg;

	localparam int VAL_W  = 32;             // vertex coordinate width
	localparam int DIFF_W = VAL_W + 1;      // exact edge difference
	localparam int PROD_W = 2 * DIFF_W;     // product of two differences
	localparam int COF_W  = PROD_W + 1;     // cofactor (difference of two products)
	localparam int LO_W   = 34;             // low slice of a cofactor for the split multiply
	localparam int HI_W   = COF_W - LO_W;   // signed high slice
	localparam int DET_W  = DIFF_W + COF_W + 2;
	localparam int OUT_W  = 48;             // inverse entry width
	localparam int QW     = OUT_W - 1;      // quotient magnitude bits
	localparam int LANES  = 9;              // matrix entries

	localparam int IN_FRAC_BITS_DEF  = 16;
	localparam int OUT_FRAC_BITS_DEF = 24;

	typedef logic signed [VAL_W-1:0] coord_t;
	typedef logic signed [OUT_W-1:0] entry_t;

	typedef struct packed {
		coord_t a_x;
		coord_t a_y;
		coord_t a_z;
		coord_t b_x;
		coord_t b_y;
		coord_t b_z;
		coord_t c_x;
		coord_t c_y;
		coord_t c_z;
		coord_t d_x;
		coord_t d_y;
		coord_t d_z;
	} vert_t;

	typedef struct packed {
		entry_t inv_r0c0;
		entry_t inv_r0c1;
		entry_t inv_r0c2;
		entry_t inv_r1c0;
		entry_t inv_r1c1;
		entry_t inv_r1c2;
		entry_t inv_r2c0;
		entry_t inv_r2c1;
		entry_t inv_r2c2;
		logic   singular;
	} inv_t;

	// next and previous index, modulo three
	function automatic int rot1(input int x);
		return (x == 2) ? 0 : x + 1;
	endfunction

	function automatic int rot2(input int x);
		return (x == 0) ? 2 : x - 1;
	endfunction

endpackage

// File: design/tbm_stream_if.sv
// Valid/ready stream channel with a typed payload.
interface tbm_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/tbm_cof.sv
// Edge differences, pairwise products and the nine cofactors (stages 1 to 3).
module tbm_cof (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               v_in,
	input  tbm_pkg::vert_t                     vert,
	output logic                               v_out,
	output logic signed [tbm_pkg::DIFF_W-1:0]  m0 [3],
	output logic signed [tbm_pkg::COF_W-1:0]   adj [tbm_pkg::LANES]
);

	logic signed [tbm_pkg::VAL_W-1:0] col [3][3];   // [column][row]
	logic signed [tbm_pkg::VAL_W-1:0] dv [3];

	logic v_s1, v_s2, v_s3;
	logic signed [tbm_pkg::DIFF_W-1:0] m_s1 [9];
	logic signed [tbm_pkg::PROD_W-1:0] pa_s2 [tbm_pkg::LANES];
	logic signed [tbm_pkg::PROD_W-1:0] pb_s2 [tbm_pkg::LANES];
	logic signed [tbm_pkg::DIFF_W-1:0] m0_s2 [3];
	logic signed [tbm_pkg::DIFF_W-1:0] m0_s3 [3];
	logic signed [tbm_pkg::COF_W-1:0]  adj_s3 [tbm_pkg::LANES];

	assign col[0] = '{vert.a_x, vert.a_y, vert.a_z};
	assign col[1] = '{vert.b_x, vert.b_y, vert.b_z};
	assign col[2] = '{vert.c_x, vert.c_y, vert.c_z};
	assign dv     = '{vert.d_x, vert.d_y, vert.d_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					m_s1[3*r+c] <= tbm_pkg::DIFF_W'(col[c][r]) - tbm_pkg::DIFF_W'(dv[r]);
				end
			end
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pa_s2[3*i+j] <= m_s1[3*tbm_pkg::rot1(j)+tbm_pkg::rot1(i)]
						* m_s1[3*tbm_pkg::rot2(j)+tbm_pkg::rot2(i)];
					pb_s2[3*i+j] <= m_s1[3*tbm_pkg::rot1(j)+tbm_pkg::rot2(i)]
						* m_s1[3*tbm_pkg::rot2(j)+tbm_pkg::rot1(i)];
				end
			end
			for (int c = 0; c < 3; c++) begin
				m0_s2[c] <= m_s1[c];
				m0_s3[c] <= m0_s2[c];
			end
			for (int l = 0; l < tbm_pkg::LANES; l++) begin
				adj_s3[l] <= tbm_pkg::COF_W'(pa_s2[l]) - tbm_pkg::COF_W'(pb_s2[l]);
			end
		end
	end

	assign v_out = v_s3;
	assign m0    = m0_s3;
	assign adj   = adj_s3;

endmodule

// File: design/tbm_det.sv
// Determinant by split multiplies, then magnitudes and signs (stages 4 to 7).
module tbm_det (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              v_in,
	input  logic signed [tbm_pkg::DIFF_W-1:0] m0 [3],
	input  logic signed [tbm_pkg::COF_W-1:0]  adj [tbm_pkg::LANES],
	output logic                              v_out,
	output logic [tbm_pkg::COF_W-1:0]         adj_mag [tbm_pkg::LANES],
	output logic                              adj_neg [tbm_pkg::LANES],
	output logic [tbm_pkg::DET_W-1:0]         det_mag,
	output logic                              det_neg,
	output logic                              det_zero
);

	localparam int PL_W = tbm_pkg::DIFF_W + tbm_pkg::LO_W + 1;
	localparam int PH_W = tbm_pkg::DIFF_W + tbm_pkg::HI_W;

	logic v_s4, v_s5, v_s6, v_s7;
	logic signed [PL_W-1:0]             pl_s4 [3];
	logic signed [PH_W-1:0]             ph_s4 [3];
	logic signed [tbm_pkg::DET_W-1:0]   term_s5 [3];
	logic signed [tbm_pkg::DET_W-1:0]   det_s6;
	logic signed [tbm_pkg::COF_W-1:0]   adj_s4 [tbm_pkg::LANES];
	logic signed [tbm_pkg::COF_W-1:0]   adj_s5 [tbm_pkg::LANES];
	logic signed [tbm_pkg::COF_W-1:0]   adj_s6 [tbm_pkg::LANES];
	logic [tbm_pkg::COF_W-1:0]          adj_mag_s7 [tbm_pkg::LANES];
	logic                               adj_neg_s7 [tbm_pkg::LANES];
	logic [tbm_pkg::DET_W-1:0]          det_mag_s7;
	logic                               det_neg_s7;
	logic                               det_zero_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_in;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// first column of the adjugate sits in lanes 0, 3 and 6
			for (int t = 0; t < 3; t++) begin
				pl_s4[t] <= m0[t] * $signed({1'b0, adj[3*t][tbm_pkg::LO_W-1:0]});
				ph_s4[t] <= m0[t] * $signed(adj[3*t][tbm_pkg::COF_W-1:tbm_pkg::LO_W]);
				term_s5[t] <= (tbm_pkg::DET_W'(ph_s4[t]) <<< tbm_pkg::LO_W)
					+ tbm_pkg::DET_W'(pl_s4[t]);
			end
			det_s6 <= term_s5[0] + term_s5[1] + term_s5[2];
			det_mag_s7  <= det_s6[tbm_pkg::DET_W-1] ? tbm_pkg::DET_W'(-det_s6)
				: tbm_pkg::DET_W'(det_s6);
			det_neg_s7  <= det_s6[tbm_pkg::DET_W-1];
			det_zero_s7 <= (det_s6 == '0);
			for (int l = 0; l < tbm_pkg::LANES; l++) begin
				adj_s4[l] <= adj[l];
				adj_s5[l] <= adj_s4[l];
				adj_s6[l] <= adj_s5[l];
				adj_mag_s7[l] <= adj_s6[l][tbm_pkg::COF_W-1] ? tbm_pkg::COF_W'(-adj_s6[l])
					: tbm_pkg::COF_W'(adj_s6[l]);
				adj_neg_s7[l] <= adj_s6[l][tbm_pkg::COF_W-1];
			end
		end
	end

	assign v_out    = v_s7;
	assign adj_mag  = adj_mag_s7;
	assign adj_neg  = adj_neg_s7;
	assign det_mag  = det_mag_s7;
	assign det_neg  = det_neg_s7;
	assign det_zero = det_zero_s7;

endmodule

// File: design/tbm_div.sv
// Nine-lane pipelined restoring divider, one quotient bit per stage, with saturation.
module tbm_div #(
	parameter int SHIFT = tbm_pkg::IN_FRAC_BITS_DEF + tbm_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       v_in,
	input  logic [tbm_pkg::COF_W-1:0]  adj_mag [tbm_pkg::LANES],
	input  logic                       adj_neg [tbm_pkg::LANES],
	input  logic [tbm_pkg::DET_W-1:0]  det_mag,
	input  logic                       det_neg,
	input  logic                       det_zero,
	output logic                       v_out,
	output tbm_pkg::inv_t              res
);

	localparam int NW = tbm_pkg::COF_W + SHIFT;
	localparam int DW = tbm_pkg::DET_W + tbm_pkg::QW;
	localparam int RW = (NW > DW) ? NW : DW;

	typedef struct packed {
		logic [RW-1:0]          rem;
		logic [tbm_pkg::QW-1:0] q;
		logic                   neg;
		logic                   sat;
	} lane_t;

	typedef struct packed {
		logic [tbm_pkg::DET_W-1:0]        d;
		logic                             zero;
		lane_t [tbm_pkg::LANES-1:0]       ln;
	} step_t;

	step_t st [tbm_pkg::QW+1];
	logic  sv [tbm_pkg::QW+1];

	// entry: scale the numerator, flag quotients that reach 2^QW
	step_t e_s0;
	logic  ev_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s0 <= 1'b0;
		end else if (en) begin
			ev_s0 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s0.d    <= det_mag;
			e_s0.zero <= det_zero;
			for (int l = 0; l < tbm_pkg::LANES; l++) begin
				e_s0.ln[l].rem <= RW'(adj_mag[l]) << SHIFT;
				e_s0.ln[l].q   <= '0;
				e_s0.ln[l].neg <= adj_neg[l] ^ det_neg;
				e_s0.ln[l].sat <= (RW'(adj_mag[l]) << SHIFT) >= (RW'(det_mag) << tbm_pkg::QW);
			end
		end
	end

	assign st[0] = e_s0;
	assign sv[0] = ev_s0;

	for (genvar t = 1; t <= tbm_pkg::QW; t++) begin : g_step
		localparam int K = tbm_pkg::QW - t;

		step_t         p_s;
		logic          pv_s;
		logic [RW-1:0] dk;
		logic          ge [tbm_pkg::LANES];
		logic [RW-1:0] rn [tbm_pkg::LANES];

		always_comb begin
			dk = RW'(st[t-1].d) << K;
			for (int l = 0; l < tbm_pkg::LANES; l++) begin
				ge[l] = st[t-1].ln[l].rem >= dk;
				rn[l] = ge[l] ? st[t-1].ln[l].rem - dk : st[t-1].ln[l].rem;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pv_s <= 1'b0;
			end else if (en) begin
				pv_s <= sv[t-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				p_s.d    <= st[t-1].d;
				p_s.zero <= st[t-1].zero;
				for (int l = 0; l < tbm_pkg::LANES; l++) begin
					p_s.ln[l].rem <= rn[l];
					p_s.ln[l].q   <= st[t-1].ln[l].q | (tbm_pkg::QW'(ge[l]) << K);
					p_s.ln[l].neg <= st[t-1].ln[l].neg;
					p_s.ln[l].sat <= st[t-1].ln[l].sat;
				end
			end
		end

		assign st[t] = p_s;
		assign sv[t] = pv_s;
	end

	// format: sign, saturate, zero on a singular matrix
	tbm_pkg::entry_t ent [tbm_pkg::LANES];
	tbm_pkg::inv_t   res_s;
	logic            rv_s;

	always_comb begin
		for (int l = 0; l < tbm_pkg::LANES; l++) begin
			if (st[tbm_pkg::QW].zero) begin
				ent[l] = '0;
			end else if (st[tbm_pkg::QW].ln[l].sat) begin
				ent[l] = st[tbm_pkg::QW].ln[l].neg ? {1'b1, {tbm_pkg::QW{1'b0}}}
					: {1'b0, {tbm_pkg::QW{1'b1}}};
			end else if (st[tbm_pkg::QW].ln[l].neg) begin
				ent[l] = -$signed({1'b0, st[tbm_pkg::QW].ln[l].q});
			end else begin
				ent[l] = $signed({1'b0, st[tbm_pkg::QW].ln[l].q});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s <= 1'b0;
		end else if (en) begin
			rv_s <= sv[tbm_pkg::QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s.inv_r0c0 <= ent[0];
			res_s.inv_r0c1 <= ent[1];
			res_s.inv_r0c2 <= ent[2];
			res_s.inv_r1c0 <= ent[3];
			res_s.inv_r1c1 <= ent[4];
			res_s.inv_r1c2 <= ent[5];
			res_s.inv_r2c0 <= ent[6];
			res_s.inv_r2c1 <= ent[7];
			res_s.inv_r2c2 <= ent[8];
			res_s.singular <= st[tbm_pkg::QW].zero;
		end
	end

	assign v_out = rv_s;
	assign res   = res_s;

endmodule

// File: design/tetrahedron_barycentric_matrix_core.sv
// Top level of the tetrahedron barycentric transform (3x3 inverse) pipeline.
// The core takes one tetrahedron (vertices A, B, C, D in signed fixed point) per transfer on
// vert and returns the inverse of the matrix with columns A-D, B-D, C-D on inv, each entry
// truncated toward zero and saturated to 48 signed bits, with singular set and all entries
// zero when the determinant is zero. It accepts one tetrahedron every cycle while the skid entry
// is empty. A result passes through 3 stages for differences and cofactors, 4 for the
// determinant, 49 in the divider (an entry stage, one per quotient bit and a format stage), and
// one output register. A one-entry skid buffer behind the output register keeps the input
// side open while a result waits, until the skid entry fills; results leave in input order.
module tetrahedron_barycentric_matrix_core #(
	parameter int IN_FRAC_BITS  = tbm_pkg::IN_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS = tbm_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	tbm_stream_if.sink    vert,
	tbm_stream_if.source  inv
);

	// pipeline advance: hold every stage while the skid entry is occupied
	logic en;

	logic                              cof_v;
	logic signed [tbm_pkg::DIFF_W-1:0] cof_m0 [3];
	logic signed [tbm_pkg::COF_W-1:0]  cof_adj [tbm_pkg::LANES];

	logic                              det_v;
	logic [tbm_pkg::COF_W-1:0]         adj_mag [tbm_pkg::LANES];
	logic                              adj_neg [tbm_pkg::LANES];
	logic [tbm_pkg::DET_W-1:0]         det_mag;
	logic                              det_neg;
	logic                              det_zero;

	logic                              div_v;
	tbm_pkg::inv_t                     div_res;

	logic                              out_v_q;
	tbm_pkg::inv_t                     out_q;
	logic                              skid_v_q;
	tbm_pkg::inv_t                     skid_q;
	logic                              pop;
	logic                              arrive;

	assign en         = !skid_v_q;
	assign vert.ready = en;

	tbm_cof u_cof (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (vert.valid),
		.vert   (vert.data),
		.v_out  (cof_v),
		.m0     (cof_m0),
		.adj    (cof_adj)
	);

	tbm_det u_det (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (cof_v),
		.m0       (cof_m0),
		.adj      (cof_adj),
		.v_out    (det_v),
		.adj_mag  (adj_mag),
		.adj_neg  (adj_neg),
		.det_mag  (det_mag),
		.det_neg  (det_neg),
		.det_zero (det_zero)
	);

	tbm_div #(
		.SHIFT (IN_FRAC_BITS + OUT_FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (det_v),
		.adj_mag  (adj_mag),
		.adj_neg  (adj_neg),
		.det_mag  (det_mag),
		.det_neg  (det_neg),
		.det_zero (det_zero),
		.v_out    (div_v),
		.res      (div_res)
	);

	// output register plus skid entry
	assign pop    = out_v_q && inv.ready;
	assign arrive = en && div_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || pop) begin
			// drain the skid entry first, else take what the pipeline delivers
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= arrive;
			end
		end else if (arrive) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			out_q <= skid_v_q ? skid_q : div_res;
		end else if (arrive) begin
			skid_q <= div_res;
		end
	end

	assign inv.valid = out_v_q;
	assign inv.data  = out_q;

	// a held skid entry implies a result waiting in the output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry valid without an output result");

	// a stalled output never loses the skid entry
	a_skid_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !(out_v_q && inv.ready)) |=> (skid_v_q && $stable(skid_q)))
		else $error("skid entry dropped or changed while stalled");

	// a singular result carries all-zero entries
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(inv.valid && inv.data.singular) |->
			(inv.data.inv_r0c0 == '0 && inv.data.inv_r0c1 == '0 && inv.data.inv_r0c2 == '0
			&& inv.data.inv_r1c0 == '0 && inv.data.inv_r1c1 == '0 && inv.data.inv_r1c2 == '0
			&& inv.data.inv_r2c0 == '0 && inv.data.inv_r2c1 == '0 && inv.data.inv_r2c2 == '0))
		else $error("singular result with nonzero entries");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the tetrahedron barycentric inverse core.
`timescale 1ns / 1ps

module testbench;
	import tbm_pkg::*;

	localparam int SHIFT       = IN_FRAC_BITS_DEF + OUT_FRAC_BITS_DEF;
	localparam int IDLE_LIMIT  = 5000;
	localparam int LATENCY     = 57;
	localparam int REPORT_MAX  = 10;

	typedef logic signed [191:0] wide_t;

	logic clk;
	logic arst_n;

	tbm_stream_if #(.payload_t(vert_t)) vert ();
	tbm_stream_if #(.payload_t(inv_t))  inv ();

	tetrahedron_barycentric_matrix_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vert   (vert),
		.inv    (inv)
	);

	inv_t inverse_q[$];
	int   mismatches;
	int   idle_cycles;
	int   rx_hold_request;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Entry k of a result, counted from inv_r0c0.
	function automatic entry_t entry_at(input inv_t r, input int k);
		return r[$bits(inv_t)-1-OUT_W*k -: OUT_W];
	endfunction

	// Truncated, saturated quotient num * 2^SHIFT / den.
	function automatic entry_t scaled_quotient(input wide_t num, input wide_t den);
		logic        neg;
		logic [191:0] n;
		logic [191:0] d;
		logic [191:0] q;
		begin
			neg = (num < 0) != (den < 0);
			n = (num < 0) ? -num : num;
			d = (den < 0) ? -den : den;
			q = (n << SHIFT) / d;
			if (q >= (192'd1 << QW))
				return neg ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
			return neg ? entry_t'(-q[OUT_W-1:0]) : entry_t'(q[OUT_W-1:0]);
		end
	endfunction

	// Inverse of the matrix with columns A-D, B-D, C-D.
	function automatic inv_t barycentric_inverse(input vert_t v);
		wide_t col[3][3];
		wide_t m[3][3];
		wide_t adj[3][3];
		wide_t det;
		wide_t dv[3];
		inv_t  r;
		int    i1, i2, j1, j2;
		begin
			col[0][0] = v.a_x; col[1][0] = v.a_y; col[2][0] = v.a_z;
			col[0][1] = v.b_x; col[1][1] = v.b_y; col[2][1] = v.b_z;
			col[0][2] = v.c_x; col[1][2] = v.c_y; col[2][2] = v.c_z;
			dv[0] = v.d_x; dv[1] = v.d_y; dv[2] = v.d_z;
			for (int rr = 0; rr < 3; rr++)
				for (int cc = 0; cc < 3; cc++)
					m[rr][cc] = col[rr][cc] - dv[rr];
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					i1 = (i + 1) % 3; i2 = (i + 2) % 3;
					j1 = (j + 1) % 3; j2 = (j + 2) % 3;
					adj[i][j] = m[j1][i1] * m[j2][i2] - m[j1][i2] * m[j2][i1];
				end
			end
			det = m[0][0] * adj[0][0] + m[0][1] * adj[1][0] + m[0][2] * adj[2][0];
			r = '0;
			if (det == 0) begin
				r.singular = 1'b1;
			end else begin
				for (int k = 0; k < LANES; k++)
					r[$bits(inv_t)-1-OUT_W*k -: OUT_W] = scaled_quotient(adj[k/3][k%3], det);
			end
			return r;
		end
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int p;
		begin
			p = $urandom_range(0, 99);
			if (p < 65) return 0;
			if (p < 95) return $urandom_range(1, 3);
			return $urandom_range(10, 40);
		end
	endfunction

	// Offer one tetrahedron, hold it until the transfer, then maybe idle.
	task automatic send_tetra(input vert_t v);
		int gap;
		begin
			vert.valid <= 1'b1;
			vert.data  <= v;
			do @(posedge clk); while (!vert.ready);
			inverse_q.push_back(barycentric_inverse(v));
			gap = pick_gap();
			if (gap > 0) begin
				vert.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic vert_t make_tetra(input coord_t ax, ay, az, bx, by, bz,
	                                     input coord_t cx, cy, cz, dx, dy, dz);
		vert_t v;
		begin
			v = '{ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz};
			return v;
		end
	endfunction

	function automatic coord_t rand_coord(input int kind);
		case (kind)
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
			default: return coord_t'($signed($urandom_range(0, 8)) - 4);
		endcase
	endfunction

	// Random tetrahedron: full range, moderate, tiny or degenerate.
	function automatic vert_t random_tetra();
		vert_t v;
		int    p, kind;
		begin
			p = $urandom_range(0, 99);
			kind = (p < 45) ? 0 : (p < 75) ? 1 : 2;
			v = make_tetra(rand_coord(kind), rand_coord(kind), rand_coord(kind),
			               rand_coord(kind), rand_coord(kind), rand_coord(kind),
			               rand_coord(kind), rand_coord(kind), rand_coord(kind),
			               rand_coord(kind), rand_coord(kind), rand_coord(kind));
			if (p >= 88) begin
				// flatten: repeat a vertex or share a coordinate plane
				case ($urandom_range(0, 3))
					0: begin v.d_x = v.a_x; v.d_y = v.a_y; v.d_z = v.a_z; end
					1: begin v.b_x = v.c_x; v.b_y = v.c_y; v.b_z = v.c_z; end
					2: begin v.a_z = v.d_z; v.b_z = v.d_z; v.c_z = v.d_z; end
					default: begin v.a_x = v.d_x; v.b_x = v.d_x; v.c_x = v.d_x; end
				endcase
			end
			return v;
		end
	endfunction

	task automatic wait_drain();
		while (inverse_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		localparam coord_t ONE  = 32'sh0001_0000;
		localparam coord_t MAXC = 32'sh7fff_ffff;
		localparam coord_t MINC = 32'sh8000_0000;
		begin
			send_tetra(make_tetra(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
			send_tetra(make_tetra(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0));
			send_tetra(make_tetra(2*ONE, 0, 0, 0, -ONE, 0, 0, 0, 4*ONE, ONE, ONE, ONE));
			send_tetra(make_tetra(MAXC, 0, 0, 0, MAXC, 0, 0, 0, MAXC, MINC, MINC, MINC));
			send_tetra(make_tetra(MINC, 0, 0, 0, MINC, 0, 0, 0, MINC, MAXC, MAXC, MAXC));
			send_tetra(make_tetra(MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, MINC,
			                      MINC, MINC, MINC));
			// a unit-LSB tetrahedron yields diagonal entries of 2^SHIFT, still below saturation
			send_tetra(make_tetra(1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0));
			send_tetra(make_tetra(-1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0));
			send_tetra(make_tetra(1, 1, 0, 0, 1, 1, 1, 0, 1, 0, 0, 0));
			send_tetra(make_tetra(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
			                      MAXC, MAXC, MAXC));
			send_tetra(make_tetra(ONE, ONE, 0, ONE, ONE, 0, 0, ONE, ONE, 0, 0, 0));
			send_tetra(make_tetra(ONE, 2*ONE, 3*ONE, 2*ONE, 4*ONE, 6*ONE, 5, 7, 9, 0, 0, 0));
			send_tetra(make_tetra(3, -7, 11, 13, 5, -2, -9, 4, 6, 1, -1, 2));
			send_tetra(make_tetra(ONE, 0, 0, 0, 0, ONE, 0, ONE, 0, 0, 0, 0));
			send_tetra(make_tetra(MINC, MINC, MINC, -1, -1, -1, 32'sh0000_ffff,
			                      32'sh7fff_0000, 32'sh5555_5555, 32'shaaaa_aaaa,
			                      32'sh0f0f_0f0f, 32'shf0f0_f0f0));
			vert.valid <= 1'b0;
			wait_drain();
		end
	endtask

	task automatic test_random_stream(input int count);
		repeat (count) send_tetra(random_tetra());
	endtask

	// Hold the receiver off long enough for the pipeline to fill and back up.
	task automatic test_output_stall();
		begin
			rx_hold_request = 300;
			repeat (150) send_tetra(random_tetra());
		end
	endtask

	task automatic test_sender_pause();
		begin
			repeat (40) send_tetra(random_tetra());
			vert.valid <= 1'b0;
			wait_drain();
			@(posedge clk);
			repeat (40) send_tetra(random_tetra());
		end
	endtask

	// Receiver: check every result transfer and drive ready with random stalls.
	initial begin
		inv_t exp_r;
		int   stall;
		stall = 0;
		inv.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (inv.valid && inv.ready) begin
				if (inverse_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected result %h", inv.data);
				end else begin
					exp_r = inverse_q.pop_front();
					for (int k = 0; k < LANES; k++) begin
						if (entry_at(inv.data, k) !== entry_at(exp_r, k)) begin
							mismatches++;
							if (mismatches <= REPORT_MAX)
								$display("entry r%0dc%0d: expected %h, got %h", k / 3, k % 3,
								         entry_at(exp_r, k), entry_at(inv.data, k));
						end
					end
					if (inv.data.singular !== exp_r.singular) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("singular: expected %b, got %b", exp_r.singular,
							         inv.data.singular);
					end
				end
			end
			if (rx_hold_request > 0) begin
				stall = rx_hold_request;
				rx_hold_request = 0;
			end else if (stall == 0 && $urandom_range(0, 3) == 0) begin
				stall = pick_gap();
			end
			if (stall > 0) begin
				stall--;
				inv.ready <= 1'b0;
			end else begin
				inv.ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((vert.valid && vert.ready) || (inv.valid && inv.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		mismatches = 0;
		rx_hold_request = 0;
		vert.valid <= 1'b0;
		vert.data  <= '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_stream(700);
		test_output_stall();
		test_sender_pause();
		test_random_stream(700);

		vert.valid <= 1'b0;
		wait_drain();
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatches == 0 && inverse_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
